@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on i_clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

@@ src/imucf_pkg.sv @@
// ----------------------------------------------------------------------------
// IMU complementary filter package
// Shared constants, codes, the CORDIC angle table and saturation helper.
// ----------------------------------------------------------------------------
package imucf_pkg;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_status;
    typedef logic [0:0] t_reg_idx;

    localparam t_op OP_MEASURE = 2'd0;
    localparam t_op OP_CAL     = 2'd1;
    localparam t_op OP_FINISH  = 2'd2;

    localparam t_status STAT_UPDATED = 2'd0;
    localparam t_status STAT_SKIPPED = 2'd1;
    localparam t_status STAT_CAL     = 2'd2;
    localparam t_status STAT_FINISH  = 2'd3;

    localparam t_reg_idx REG_GYRO_SCALE  = 1'd0;
    localparam t_reg_idx REG_GYRO_WEIGHT = 1'd1;

    localparam int CFG_DATA_W = 17;
    localparam logic [15:0] GYRO_SCALE_RESET  = 16'd500;
    localparam logic [16:0] GYRO_WEIGHT_RESET = 17'd62915;
    localparam logic [16:0] WEIGHT_ONE        = 17'd65536;

    localparam int CALIBRATION_SAMPLES_DEF = 256;
    localparam int CORDIC_STEPS_DEF        = 20;

    // divider: 64-bit dividend, divisor below 2^DIV_W, DIV_BITS quotient bits a cycle
    localparam int DIV_W      = 20;
    localparam int DIV_NUM_W  = 64;
    localparam int DIV_BITS   = 4;
    localparam int DIV_CYCLES = DIV_NUM_W / DIV_BITS;
    localparam logic [DIV_W-1:0] USEC_PER_SEC = 20'd1000000;

    localparam int ATAN_IDX_W = 5;

    // atan(2^-i) in Q16.16 degrees
    function automatic logic signed [31:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:    v = 32'sd2949120;
            5'd1:    v = 32'sd1740967;
            5'd2:    v = 32'sd919879;
            5'd3:    v = 32'sd466945;
            5'd4:    v = 32'sd234379;
            5'd5:    v = 32'sd117304;
            5'd6:    v = 32'sd58666;
            5'd7:    v = 32'sd29335;
            5'd8:    v = 32'sd14668;
            5'd9:    v = 32'sd7334;
            5'd10:   v = 32'sd3667;
            5'd11:   v = 32'sd1833;
            5'd12:   v = 32'sd917;
            5'd13:   v = 32'sd458;
            5'd14:   v = 32'sd229;
            5'd15:   v = 32'sd115;
            5'd16:   v = 32'sd57;
            5'd17:   v = 32'sd29;
            5'd18:   v = 32'sd14;
            5'd19:   v = 32'sd7;
            5'd20:   v = 32'sd4;
            5'd21:   v = 32'sd2;
            5'd22:   v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ src/imucf_ifs.sv @@
// ----------------------------------------------------------------------------
// IMU complementary filter channels
// Sample input channel and attitude result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface imucf_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic [31:0]        timestamp_us;

    modport source (output valid, op, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    timestamp_us, input ready);
    modport sink (input valid, op, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  timestamp_us, output ready);
endinterface

interface imucf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] roll_deg;
    logic signed [31:0] pitch_deg;
    logic signed [31:0] yaw_deg;
    logic [31:0]        elapsed_us;
    logic [1:0]         status;

    modport source (output valid, roll_deg, pitch_deg, yaw_deg, elapsed_us, status,
                    input ready);
    modport sink (input valid, roll_deg, pitch_deg, yaw_deg, elapsed_us, status,
                  output ready);
endinterface

@@ src/imucf_isqrt.sv @@
// ----------------------------------------------------------------------------
// Iterative square root
// Floor square root of a 32-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module imucf_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_val,
    output logic        o_busy,
    output logic [15:0] o_root
);
    logic        r_busy;
    logic [31:0] r_v;
    logic [31:0] r_r;
    logic [31:0] r_bit;
    logic [32:0] trial;

    assign trial = {1'b0, r_r} + {1'b0, r_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_v    <= i_val;
            r_r    <= '0;
            r_bit  <= 32'h4000_0000;
        end else if (r_busy) begin
            if ({1'b0, r_v} >= trial) begin
                r_v <= r_v - trial[31:0];
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
            if (r_bit == 32'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_r[15:0];
endmodule

@@ src/imucf_cordic.sv @@
// ----------------------------------------------------------------------------
// CORDIC arctangent
// Vectoring mode, one micro-rotation per cycle, angle in Q16.16 degrees.
// ----------------------------------------------------------------------------
module imucf_cordic #(
    parameter int STEPS = imucf_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [16:0] i_num,
    input  logic [15:0]        i_den,
    output logic               o_busy,
    output logic signed [31:0] o_angle
);
    import imucf_pkg::*;

    localparam int CW = $clog2(STEPS + 1);

    logic               r_busy;
    logic [CW-1:0]      r_i;
    logic signed [35:0] r_x;
    logic signed [35:0] r_y;
    logic signed [31:0] r_z;
    logic signed [35:0] xs;
    logic signed [35:0] ys;
    logic signed [31:0] step_angle;

    assign xs         = r_x >>> r_i;
    assign ys         = r_y >>> r_i;
    assign step_angle = atan_q16(ATAN_IDX_W'(r_i));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_i    <= '0;
            r_x    <= $signed({4'b0, i_den, 16'b0});
            r_y    <= {{3{i_num[16]}}, i_num, 16'b0};
            r_z    <= '0;
        end else if (r_busy) begin
            if (!r_y[35]) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + step_angle;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - step_angle;
            end
            r_i <= r_i + 1'b1;
            if (r_i == CW'(STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_angle = r_z;
endmodule

@@ src/imucf_div.sv @@
// ----------------------------------------------------------------------------
// Iterative divider
// Unsigned 64-bit by narrow divisor, restoring, several quotient bits a cycle.
// ----------------------------------------------------------------------------
module imucf_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [imucf_pkg::DIV_NUM_W-1:0]     i_num,
    input  logic [imucf_pkg::DIV_W-1:0]         i_den,
    output logic                                o_busy,
    output logic [imucf_pkg::DIV_NUM_W-1:0]     o_quot
);
    import imucf_pkg::*;

    localparam int CNT_W = $clog2(DIV_CYCLES);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_den;
    logic [DIV_NUM_W-1:0] n_num;
    logic [DIV_W-1:0]     n_rem;

    // quotient bits shift in at the bottom as dividend bits leave the top
    always_comb begin
        logic [DIV_W:0] t;
        n_num = r_num;
        n_rem = r_rem;
        for (int j = 0; j < DIV_BITS; j++) begin
            t     = {n_rem, n_num[DIV_NUM_W-1]};
            n_num = {n_num[DIV_NUM_W-2:0], 1'b0};
            if (t >= {1'b0, r_den}) begin
                t        = t - {1'b0, r_den};
                n_num[0] = 1'b1;
            end
            n_rem = t[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_num  <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIV_CYCLES - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_num;
endmodule

@@ src/imu_complementary_attitude_filter_unit.sv @@
// ----------------------------------------------------------------------------
// IMU complementary attitude filter
// Roll, pitch and yaw from raw accelerometer and gyro samples, Q16.16 degrees.
// ----------------------------------------------------------------------------
// One sample is worked on at a time; i_in.ready is high only while the unit
// is idle. A measure or calibration sample passes through two square roots,
// two CORDIC passes and three divisions by 10^6 for the gyro integrators,
// with one shared multiplier for the squares, rate scaling, rate*time and
// blend products. A finish command runs five divisions by CALIBRATION_SAMPLES.
// A non-finish sample with zero accel x or y answers in the cycle after
// accept. The result is held until taken, and the next transaction can be
// accepted in the cycle after the result is taken.
`include "assert_macros.svh"

module imu_complementary_attitude_filter_unit #(
    parameter int CALIBRATION_SAMPLES = imucf_pkg::CALIBRATION_SAMPLES_DEF,
    parameter int CORDIC_STEPS        = imucf_pkg::CORDIC_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    imucf_in_if.sink                        i_in,
    imucf_out_if.source                     o_out,
    input  logic                            i_cfg_we,
    input  imucf_pkg::t_reg_idx             i_cfg_idx,
    input  logic [imucf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import imucf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_ROOT, S_ATAN, S_RATE, S_ADJ, S_INT, S_BLEND, S_FIN, S_OUT
    } t_state;

    t_state             r_state;
    logic [1:0]         r_cnt;
    logic [2:0]         r_sel;

    logic [15:0]        r_scale;
    logic [16:0]        r_weight;

    logic signed [31:0] r_integ [3];
    logic [31:0]        r_last;
    logic signed [31:0] r_abias [2];
    logic signed [31:0] r_rbias [3];
    logic [47:0]        r_sum [5];

    t_op                r_op;
    logic signed [15:0] r_ax;
    logic signed [15:0] r_ay;
    logic signed [15:0] r_az;
    logic signed [15:0] r_gyr [3];
    logic [31:0]        r_ts;

    logic [31:0]        r_sq [2];
    logic signed [31:0] r_ang [2];
    logic signed [31:0] r_rate [3];
    logic [31:0]        r_dt;
    logic               r_neg;
    logic signed [65:0] r_pacc;
    logic signed [65:0] r_prod;

    logic signed [31:0] r_roll;
    logic signed [31:0] r_pitch;
    logic signed [31:0] r_yaw;
    logic [31:0]        r_elapsed;
    t_status            r_status;

    logic signed [32:0] m_a;
    logic signed [32:0] m_b;
    logic [16:0]        w_eff;
    logic [16:0]        w_acc;
    logic signed [31:0] rate_sel;
    logic [31:0]        rate_mag;
    logic [47:0]        sum_sel;
    logic [47:0]        sum_mag;
    logic signed [65:0] blend_v;

    logic               sqrt_start;
    logic               sqrt_busy;
    logic [15:0]        sqrt_root;
    logic               atan_start;
    logic               atan_busy;
    logic signed [16:0] atan_num;
    logic signed [31:0] atan_angle;
    logic               div_start;
    logic               div_busy;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_W-1:0]   div_den;
    logic [DIV_NUM_W-1:0] div_quot;

    assign w_eff    = (r_weight > WEIGHT_ONE) ? WEIGHT_ONE : r_weight;
    assign w_acc    = WEIGHT_ONE - w_eff;
    assign rate_sel = r_rate[r_sel[1:0]];
    assign rate_mag = rate_sel[31] ? 32'(-rate_sel) : rate_sel;
    assign sum_sel  = r_sum[r_sel];
    assign sum_mag  = sum_sel[47] ? 48'(-sum_sel) : sum_sel;
    assign blend_v  = (r_pacc + r_prod + 66'sd32768) >>> 16;

    // shared multiplier operand select
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            S_SQ: begin
                case (r_cnt)
                    2'd0: begin
                        m_a = {{17{r_ax[15]}}, r_ax};
                        m_b = m_a;
                    end
                    2'd1: begin
                        m_a = {{17{r_ay[15]}}, r_ay};
                        m_b = m_a;
                    end
                    2'd2: begin
                        m_a = {{17{r_az[15]}}, r_az};
                        m_b = m_a;
                    end
                    default: ;
                endcase
            end
            S_RATE: begin
                if (r_cnt != 2'd3) begin
                    m_a = {{17{r_gyr[r_cnt][15]}}, r_gyr[r_cnt]};
                    m_b = {17'b0, r_scale};
                end
            end
            S_INT: begin
                m_a = {1'b0, rate_mag};
                m_b = {1'b0, r_dt};
            end
            S_BLEND: begin
                if (r_cnt == 2'd0) begin
                    m_a = {16'b0, w_eff};
                    m_b = {r_integ[r_sel[1:0]][31], r_integ[r_sel[1:0]]};
                end else begin
                    m_a = {16'b0, w_acc};
                    m_b = {r_ang[r_sel[0]][31], r_ang[r_sel[0]]};
                end
            end
            default: ;
        endcase
    end

    assign sqrt_start = (r_state == S_ROOT) && (r_cnt == 2'd0);
    assign atan_start = (r_state == S_ATAN) && (r_cnt == 2'd0);
    assign atan_num   = r_sel[0] ? 17'(-{r_ax[15], r_ax}) : {r_ay[15], r_ay};
    assign div_start  = ((r_state == S_INT) && (r_cnt == 2'd1)) ||
                        ((r_state == S_FIN) && (r_cnt == 2'd0));
    assign div_num    = (r_state == S_FIN) ? {16'b0, sum_mag} : r_prod[63:0];
    assign div_den    = (r_state == S_FIN) ? DIV_W'(CALIBRATION_SAMPLES) : USEC_PER_SEC;

    imucf_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_val   (r_sq[r_sel[0]]),
        .o_busy  (sqrt_busy),
        .o_root  (sqrt_root)
    );

    imucf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (atan_start),
        .i_num   (atan_num),
        .i_den   (sqrt_root),
        .o_busy  (atan_busy),
        .o_angle (atan_angle)
    );

    imucf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= GYRO_SCALE_RESET;
            r_weight <= GYRO_WEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GYRO_SCALE:  r_scale  <= i_cfg_data[15:0];
                REG_GYRO_WEIGHT: r_weight <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_sel   <= '0;
            r_last  <= '0;
            for (int i = 0; i < 3; i++) begin
                r_integ[i] <= '0;
                r_rbias[i] <= '0;
            end
            for (int i = 0; i < 2; i++) begin
                r_abias[i] <= '0;
            end
            for (int i = 0; i < 5; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op     <= i_in.op;
                        r_ax     <= i_in.accel_x;
                        r_ay     <= i_in.accel_y;
                        r_az     <= i_in.accel_z;
                        r_gyr[0] <= i_in.gyro_x;
                        r_gyr[1] <= i_in.gyro_y;
                        r_gyr[2] <= i_in.gyro_z;
                        r_ts     <= i_in.timestamp_us;
                        r_cnt    <= '0;
                        r_sel    <= '0;
                        if (i_in.op == OP_FINISH) begin
                            r_state <= S_FIN;
                        end else if (i_in.accel_x == '0 || i_in.accel_y == '0) begin
                            r_roll    <= '0;
                            r_pitch   <= '0;
                            r_yaw     <= '0;
                            r_elapsed <= '0;
                            r_status  <= STAT_SKIPPED;
                            r_state   <= S_OUT;
                        end else begin
                            r_state <= S_SQ;
                        end
                    end
                end
                S_SQ: begin
                    r_cnt <= r_cnt + 1'b1;
                    case (r_cnt)
                        2'd1: r_sq[0] <= r_prod[31:0];
                        2'd2: r_sq[1] <= r_prod[31:0];
                        2'd3: begin
                            r_sq[0] <= r_sq[0] + r_prod[31:0];
                            r_sq[1] <= r_sq[1] + r_prod[31:0];
                            r_state <= S_ROOT;
                        end
                        default: ;
                    endcase
                end
                S_ROOT: begin
                    if (r_cnt == 2'd0) begin
                        r_cnt <= 2'd1;
                    end else if (!sqrt_busy) begin
                        r_cnt   <= '0;
                        r_state <= S_ATAN;
                    end
                end
                S_ATAN: begin
                    if (r_cnt == 2'd0) begin
                        r_cnt <= 2'd1;
                    end else if (!atan_busy) begin
                        r_ang[r_sel[0]] <= atan_angle;
                        r_cnt <= '0;
                        if (r_sel[0]) begin
                            r_sel   <= '0;
                            r_state <= S_RATE;
                        end else begin
                            r_sel   <= 3'd1;
                            r_state <= S_ROOT;
                        end
                    end
                end
                S_RATE: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt != 2'd0) begin
                        r_rate[r_cnt - 2'd1] <= r_prod[31:0];
                    end
                    if (r_cnt == 2'd3) begin
                        r_state <= S_ADJ;
                    end
                end
                S_ADJ: begin
                    if (r_op == OP_CAL) begin
                        if (r_az != '0) begin
                            for (int i = 0; i < 2; i++) begin
                                r_sum[i] <= r_sum[i] + {{16{r_ang[i][31]}}, r_ang[i]};
                            end
                            for (int i = 0; i < 3; i++) begin
                                r_sum[i+2] <= r_sum[i+2] + {{16{r_rate[i][31]}}, r_rate[i]};
                            end
                        end
                    end else begin
                        for (int i = 0; i < 2; i++) begin
                            r_ang[i] <= sat32(66'(r_ang[i]) - 66'(r_abias[i]));
                        end
                        for (int i = 0; i < 3; i++) begin
                            r_rate[i] <= sat32(66'(r_rate[i]) - 66'(r_rbias[i]));
                        end
                    end
                    r_dt    <= r_ts - r_last;
                    r_last  <= r_ts;
                    r_cnt   <= '0;
                    r_sel   <= '0;
                    r_state <= S_INT;
                end
                S_INT: begin
                    case (r_cnt)
                        2'd0: begin
                            r_neg <= rate_sel[31];
                            r_cnt <= 2'd1;
                        end
                        2'd1: r_cnt <= 2'd2;
                        default: begin
                            if (!div_busy) begin
                                r_integ[r_sel[1:0]] <= r_integ[r_sel[1:0]] +
                                    (r_neg ? -div_quot[31:0] : div_quot[31:0]);
                                r_cnt <= '0;
                                if (r_sel == 3'd2) begin
                                    r_sel   <= '0;
                                    r_state <= S_BLEND;
                                end else begin
                                    r_sel <= r_sel + 1'b1;
                                end
                            end
                        end
                    endcase
                end
                S_BLEND: begin
                    case (r_cnt)
                        2'd0: r_cnt <= 2'd1;
                        2'd1: begin
                            r_pacc <= r_prod;
                            r_cnt  <= 2'd2;
                        end
                        default: begin
                            r_cnt <= '0;
                            if (r_sel[0]) begin
                                r_pitch   <= sat32(blend_v);
                                r_yaw     <= r_integ[2];
                                r_elapsed <= r_dt;
                                r_status  <= (r_op == OP_CAL) ? STAT_CAL : STAT_UPDATED;
                                r_state   <= S_OUT;
                            end else begin
                                r_roll <= sat32(blend_v);
                                r_sel  <= 3'd1;
                            end
                        end
                    endcase
                end
                S_FIN: begin
                    if (r_cnt == 2'd0) begin
                        r_neg <= sum_sel[47];
                        r_cnt <= 2'd1;
                    end else if (!div_busy) begin
                        if (r_sel < 3'd2) begin
                            r_abias[r_sel[0]] <= sat32(r_neg ? -66'(div_quot)
                                                             : 66'(div_quot));
                        end else begin
                            r_rbias[2'(r_sel - 3'd2)] <= sat32(r_neg ? -66'(div_quot)
                                                                     : 66'(div_quot));
                        end
                        r_cnt <= '0;
                        if (r_sel == 3'd4) begin
                            for (int i = 0; i < 5; i++) begin
                                r_sum[i] <= '0;
                            end
                            for (int i = 0; i < 3; i++) begin
                                r_integ[i] <= '0;
                            end
                            r_roll    <= '0;
                            r_pitch   <= '0;
                            r_yaw     <= '0;
                            r_elapsed <= '0;
                            r_status  <= STAT_FINISH;
                            r_state   <= S_OUT;
                        end else begin
                            r_sel <= r_sel + 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = (r_state == S_OUT);
    assign o_out.roll_deg   = r_roll;
    assign o_out.pitch_deg  = r_pitch;
    assign o_out.yaw_deg    = r_yaw;
    assign o_out.elapsed_us = r_elapsed;
    assign o_out.status     = r_status;

    `ASSERT_NEVER(a_in_out_excl, i_in.ready && o_out.valid, "ready while result pending")
    `ASSERT_PROP(a_busy_after_accept, i_in.valid && i_in.ready |=> !i_in.ready, "ready after accept")
    `ASSERT_PROP(a_skip_zero, o_out.valid && o_out.status == STAT_SKIPPED |-> o_out.roll_deg == 0 && o_out.pitch_deg == 0 && o_out.yaw_deg == 0 && o_out.elapsed_us == 0, "skipped result not zero")
endmodule

@@ tb/sv/tb_imu_complementary_attitude_filter_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Attitude filter unit testbench
// Drives raw IMU samples and configuration writes into the filter, predicts
// every attitude result with a behavioral fixed-point model kept in step with
// the accepted transactions, and compares results field by field in order.
// ----------------------------------------------------------------------------
module tb_imu_complementary_attitude_filter_unit;
    import imucf_pkg::*;

    localparam int CAL_COUNT  = 256;
    localparam int CORDIC_N   = 20;
    localparam int N_RANDOM   = 1280;

    localparam longint ATAN_DEG [0:19] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
    };

    typedef struct {
        t_op                op;
        logic signed [15:0] ax, ay, az, gx, gy, gz;
        logic [31:0]        ts;
    } t_sample;

    typedef struct {
        logic signed [31:0] roll, pitch, yaw;
        logic [31:0]        elapsed;
        t_status            status;
    } t_attitude;

    typedef struct {
        t_sample   smp;
        bit        typed;
        t_attitude att;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    t_reg_idx i_cfg_idx = REG_GYRO_SCALE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    imucf_in_if  in_ch ();
    imucf_out_if out_ch ();

    imu_complementary_attitude_filter_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [15:0]        m_scale;
    logic [16:0]        m_weight;
    logic [31:0]        m_int [3];
    logic [31:0]        m_last;
    logic signed [31:0] m_ang_bias [2];
    logic signed [31:0] m_rate_bias [3];
    logic [47:0]        m_sum [5];

    t_attitude pending_att [$];
    t_row      dir_rows [$];
    int        n_err = 0;
    int        n_shown = 0;
    bit        hold_rx = 1'b0;
    int        burst_left = 0;
    logic [31:0] ts_now = 0;

    function automatic longint sat_s32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint tilt_deg(longint num, longint den);
        longint x, y, z, xs, ys;
        x = den * 65536;
        y = num * 65536;
        z = 0;
        for (int i = 0; i < CORDIC_N; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += ATAN_DEG[i];
            end else begin
                x -= ys; y += xs; z -= ATAN_DEG[i];
            end
        end
        return z;
    endfunction

    function automatic longint blend_deg(longint g, longint a);
        longint w;
        w = (m_weight > 17'd65536) ? 64'sd65536 : longint'(m_weight);
        return sat_s32((w * g + (65536 - w) * a + 32768) >>> 16);
    endfunction

    function automatic t_attitude predict_attitude(t_sample s);
        t_attitude r;
        longint ang [2];
        longint rate [3];
        longint ax, ay, az, d;
        logic [31:0] dt;
        r = '{roll: 0, pitch: 0, yaw: 0, elapsed: 0, status: STAT_UPDATED};
        ax = s.ax; ay = s.ay; az = s.az;
        if (s.op == OP_FINISH) begin
            for (int i = 0; i < 5; i++) begin
                d = sat_s32(longint'($signed(m_sum[i])) / CAL_COUNT);
                if (i < 2) m_ang_bias[i] = d[31:0];
                else m_rate_bias[i-2] = d[31:0];
                m_sum[i] = '0;
            end
            for (int i = 0; i < 3; i++) m_int[i] = '0;
            r.status = STAT_FINISH;
            return r;
        end
        if (ax == 0 || ay == 0) begin
            r.status = STAT_SKIPPED;
            return r;
        end
        ang[0] = tilt_deg(ay, int_sqrt(ax * ax + az * az));
        ang[1] = tilt_deg(-ax, int_sqrt(ay * ay + az * az));
        rate[0] = longint'(s.gx) * longint'(m_scale);
        rate[1] = longint'(s.gy) * longint'(m_scale);
        rate[2] = longint'(s.gz) * longint'(m_scale);
        if (s.op == OP_CAL) begin
            if (az != 0) begin
                for (int i = 0; i < 2; i++) m_sum[i] = m_sum[i] + ang[i][47:0];
                for (int i = 0; i < 3; i++) m_sum[i+2] = m_sum[i+2] + rate[i][47:0];
            end
        end else begin
            for (int i = 0; i < 2; i++) ang[i] = sat_s32(ang[i] - m_ang_bias[i]);
            for (int i = 0; i < 3; i++) rate[i] = sat_s32(rate[i] - m_rate_bias[i]);
        end
        dt = s.ts - m_last;
        m_last = s.ts;
        for (int i = 0; i < 3; i++) begin
            d = (rate[i] * longint'(dt)) / 1000000;
            m_int[i] = m_int[i] + d[31:0];
        end
        r.roll    = 32'(blend_deg(longint'($signed(m_int[0])), ang[0]));
        r.pitch   = 32'(blend_deg(longint'($signed(m_int[1])), ang[1]));
        r.yaw     = m_int[2];
        r.elapsed = dt;
        r.status  = (s.op == OP_CAL) ? STAT_CAL : STAT_UPDATED;
        return r;
    endfunction

    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_GYRO_SCALE) m_scale = val[15:0];
        else m_weight = val;
    endtask

    // offer one sample; record the expectation on the accepting edge
    task automatic send_sample(t_sample s, bit typed, t_attitude typed_att);
        t_attitude p;
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 20)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_ch.valid        <= 1'b1;
        in_ch.op           <= s.op;
        in_ch.accel_x      <= s.ax;
        in_ch.accel_y      <= s.ay;
        in_ch.accel_z      <= s.az;
        in_ch.gyro_x       <= s.gx;
        in_ch.gyro_y       <= s.gy;
        in_ch.gyro_z       <= s.gz;
        in_ch.timestamp_us <= s.ts;
        do @(posedge i_clk); while (!in_ch.ready);
        p = predict_attitude(s);
        pending_att.push_back(typed ? typed_att : p);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_att.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] axis_value(bit wide);
        if (wide) return 16'($urandom());
        return $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
    endfunction

    function automatic t_sample random_sample(t_op op, bit wide);
        t_sample s;
        s.op = op;
        s.ax = axis_value(wide);
        s.ay = axis_value(wide);
        s.az = axis_value(wide);
        s.gx = axis_value(wide);
        s.gy = axis_value(wide);
        s.gz = axis_value(wide);
        if ($urandom_range(0, 40) == 0) ts_now = $urandom();
        else ts_now = ts_now + $urandom_range(0, 30000);
        s.ts = ts_now;
        return s;
    endfunction

    function automatic t_row row(t_op op, int ax, int ay, int az, int gx, int gy, int gz,
                                 logic [31:0] ts, bit typed, t_status st);
        t_row r;
        r.smp = '{op: op, ax: 16'(ax), ay: 16'(ay), az: 16'(az), gx: 16'(gx),
                  gy: 16'(gy), gz: 16'(gz), ts: ts};
        r.typed = typed;
        r.att = '{roll: 0, pitch: 0, yaw: 0, elapsed: 0, status: st};
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_attitude e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_att.size() == 0) begin
                n_err++;
                if (n_shown < 10) begin
                    n_shown++;
                    $display("unexpected result status=%0d", out_ch.status);
                end
            end else begin
                e = pending_att.pop_front();
                if (out_ch.roll_deg !== e.roll || out_ch.pitch_deg !== e.pitch ||
                    out_ch.yaw_deg !== e.yaw || out_ch.elapsed_us !== e.elapsed ||
                    out_ch.status !== e.status) begin
                    n_err++;
                    if (n_shown < 10) begin
                        n_shown++;
                        $display("mismatch exp r=%0d p=%0d y=%0d dt=%0d st=%0d",
                                 e.roll, e.pitch, e.yaw, e.elapsed, e.status);
                        $display("         got r=%0d p=%0d y=%0d dt=%0d st=%0d",
                                 out_ch.roll_deg, out_ch.pitch_deg, out_ch.yaw_deg,
                                 out_ch.elapsed_us, out_ch.status);
                    end
                end
            end
        end
    end

    // receiver: random stall pattern drawn from three modes, plus a long hold on request
    initial begin
        int mode;
        out_ch.ready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            for (int c = 0; c < 64; c++) begin
                @(negedge i_clk);
                if (hold_rx) begin
                    out_ch.ready <= 1'b0;
                    repeat (400) @(negedge i_clk);
                    hold_rx = 1'b0;
                end
                case (mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: out_ch.ready <= ((c % 8) < 3);
                endcase
            end
        end
    end

    initial begin
        #8000000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        t_attitude none;
        t_sample s;
        int run_len, wait_cyc;
        logic [15:0] scale_set [5];
        logic [16:0] weight_set [5];

        none = '{roll: 0, pitch: 0, yaw: 0, elapsed: 0, status: STAT_UPDATED};
        in_ch.valid <= 1'b0;
        in_ch.op <= OP_MEASURE;
        in_ch.accel_x <= '0; in_ch.accel_y <= '0; in_ch.accel_z <= '0;
        in_ch.gyro_x <= '0; in_ch.gyro_y <= '0; in_ch.gyro_z <= '0;
        in_ch.timestamp_us <= '0;

        m_scale = GYRO_SCALE_RESET;
        m_weight = GYRO_WEIGHT_RESET;
        m_last = '0;
        for (int i = 0; i < 3; i++) begin m_int[i] = '0; m_rate_bias[i] = '0; end
        for (int i = 0; i < 2; i++) m_ang_bias[i] = '0;
        for (int i = 0; i < 5; i++) m_sum[i] = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero accel skips, empty finish, extremes, op three,
        // calibration with flat z, timestamp wrap
        dir_rows.push_back(row(OP_MEASURE, 0, 100, 100, 5, 5, 5, 10, 1, STAT_SKIPPED));
        dir_rows.push_back(row(OP_MEASURE, 100, 0, 100, 5, 5, 5, 10, 1, STAT_SKIPPED));
        dir_rows.push_back(row(OP_FINISH, 0, 0, 0, 0, 0, 0, 10, 1, STAT_FINISH));
        dir_rows.push_back(row(OP_MEASURE, 1, 1, 0, 0, 0, 0, 0, 0, STAT_UPDATED));
        dir_rows.push_back(row(OP_MEASURE, -32768, -32768, -32768, -32768, -32768, -32768,
                               1000, 0, STAT_UPDATED));
        dir_rows.push_back(row(OP_MEASURE, 32767, 32767, 32767, 32767, 32767, 32767,
                               1001000, 0, STAT_UPDATED));
        dir_rows.push_back(row(2'd3, -1, 1, 16384, 100, -100, 7, 1002000, 0, STAT_UPDATED));
        dir_rows.push_back(row(OP_CAL, 300, -200, 0, 40, 50, 60, 1003000, 0, STAT_CAL));
        dir_rows.push_back(row(OP_CAL, 32767, -32768, 32767, -32768, 32767, -1,
                               1004000, 0, STAT_CAL));
        dir_rows.push_back(row(OP_CAL, -32768, 32767, -32768, 32767, -32768, 1,
                               1005000, 0, STAT_CAL));
        dir_rows.push_back(row(OP_CAL, 120, 80, 16000, 30, -20, 10, 1006000, 0, STAT_CAL));
        dir_rows.push_back(row(OP_FINISH, 1, 1, 1, 1, 1, 1, 1007000, 1, STAT_FINISH));
        dir_rows.push_back(row(OP_MEASURE, 120, 80, 16000, 30, -20, 10, 32'hFFFF_FFF0, 0,
                               STAT_UPDATED));
        dir_rows.push_back(row(OP_MEASURE, -500, 700, -16000, -300, 200, 100, 32'd5, 0,
                               STAT_UPDATED));
        dir_rows.push_back(row(2'd3, 0, -5, 9, 1, 2, 3, 32'd99, 1, STAT_SKIPPED));
        foreach (dir_rows[k]) send_sample(dir_rows[k].smp, dir_rows[k].typed, dir_rows[k].att);
        ts_now = 32'd100;

        // output held back while the sender keeps offering
        hold_rx = 1'b1;
        for (int k = 0; k < 6; k++) send_sample(random_sample(OP_MEASURE, 1), 0, none);
        drain_results();

        scale_set  = '{16'd0, 16'd65535, 16'd1, 16'($urandom()), GYRO_SCALE_RESET};
        weight_set = '{17'd0, WEIGHT_ONE, 17'h1FFFF, 17'($urandom_range(0, 65536)),
                       GYRO_WEIGHT_RESET};

        for (int ph = 0; ph < 5; ph++) begin
            drain_results();
            write_reg(REG_GYRO_SCALE, CFG_DATA_W'(scale_set[ph]));
            write_reg(REG_GYRO_WEIGHT, weight_set[ph]);
            run_len = 0;
            while (run_len < N_RANDOM / 5) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        // calibration run: steady pose with noise, then finish
                        s = random_sample(OP_CAL, $urandom_range(0, 3) == 0);
                        for (int k = $urandom_range(2, 30); k > 0; k--) begin
                            s.ax += 16'($urandom_range(0, 20)) - 16'sd10;
                            s.gz += 16'($urandom_range(0, 20)) - 16'sd10;
                            ts_now += $urandom_range(500, 5000);
                            s.ts = ts_now;
                            if ($urandom_range(0, 15) == 0) s.az = 0;
                            send_sample(s, 0, none);
                            run_len++;
                        end
                        s.op = OP_FINISH;
                        send_sample(s, 0, none);
                        run_len++;
                    end
                    3: begin
                        s = random_sample(t_op'($urandom_range(0, 3)), 1);
                        if ($urandom_range(0, 1)) s.ax = 0; else s.ay = 0;
                        send_sample(s, 0, none);
                        run_len++;
                    end
                    default: begin
                        for (int k = $urandom_range(5, 40); k > 0; k--) begin
                            s = random_sample($urandom_range(0, 9) == 0 ? t_op'(3) : OP_MEASURE,
                                              $urandom_range(0, 2) == 0);
                            send_sample(s, 0, none);
                            run_len++;
                        end
                    end
                endcase
                if ($urandom_range(0, 20) == 0) drain_results();
            end
        end

        in_ch.valid <= 1'b0;
        wait_cyc = 0;
        while (pending_att.size() != 0 && wait_cyc < 200000) begin
            @(negedge i_clk);
            wait_cyc++;
        end
        repeat (200) @(negedge i_clk);
        if (pending_att.size() != 0) n_err++;
        if (n_err == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
